// ===== sv/mipmap_build_and_bilinear_sampler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Mipmap sampler assertion macros
// Shared macros for the concurrent checks of the mipmap sampler.
// ----------------------------------------------------------------------------
`ifndef MIPMAP_BUILD_AND_BILINEAR_SAMPLER_TOP_MACROS_SVH
`define MIPMAP_BUILD_AND_BILINEAR_SAMPLER_TOP_MACROS_SVH

// Checks a property that is disabled while reset is asserted.
`define MBS_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checks a property that also holds during reset.
`define MBS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== sv/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Mipmap sampler package
// Transaction types, request codes and level offsets of the texel store.
// ----------------------------------------------------------------------------
`default_nettype none

package mbs_pkg;

    localparam int MAX_LEVEL_DEF = 7;
    localparam int LVL_W         = 4;
    localparam int FULL_SCALE    = 65280;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_BUILD  = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [13:0]       texel_index;
        logic [7:0]        red_in;
        logic [7:0]        green_in;
        logic [7:0]        blue_in;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic [3:0]        sample_level;
    } in_item_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
    } out_item_t;

    // The sum of 4^i for i below n is the bit pattern 0101... over the low 2n bits.
    function automatic logic [31:0] level_offset(input logic [LVL_W-1:0] n);
        logic [31:0] mask;
        begin
            mask = (32'd1 << (2 * n)) - 32'd1;
            return mask & 32'h5555_5555;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/mipmap_build_and_bilinear_sampler_top.sv =====
// ----------------------------------------------------------------------------
// Mipmap build and bilinear sampler
// Texel store with base writes, 2x2 mip chain build and bilinear sampling.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | in_data   (in_item_t)
//  out     | out_valid / out_stall | out_data  (out_item_t)
//  cfg     | cfg_valid / cfg_ready | cfg_data  (base_level)
//
// A write is done in its accept cycle. A sample is accepted, makes four reads of
// the single-port texel store, waits for the last read data and blends; the blend
// waits while a stalled result is held. A build makes four reads and one write
// per derived texel. Reset is asynchronous and clears control state only; the
// store is not cleared. A held result does not block the next input transaction.
`default_nettype none

module mipmap_build_and_bilinear_sampler_top
    import mbs_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [2:0] cfg_data
);

    localparam int DEPTH = ((1 << (2 * (MAX_LEVEL + 1))) - 1) / 3;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_LEVEL > 0) ? MAX_LEVEL : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_BUILD  = 4'b0010,
        ST_SAMPLE = 4'b0100,
        ST_BLEND  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CW-1:0] first;
        logic [CW-1:0] second;
        logic [15:0]   w;
    } tap_t;

    function automatic tap_t calc_tap(input logic [16:0] c, input logic [LVL_W-1:0] lvl);
        logic [30:0] t;
        logic [14:0] hi;
        logic [14:0] smax;
        logic [14:0] f;
        logic [14:0] s;
        tap_t        r;
        begin
            t    = (31'(c) << lvl) + 31'd32768;
            hi   = t[30:16];
            smax = (15'd1 << lvl) - 15'd1;
            f    = (hi == 15'd0) ? 15'd0 : hi - 15'd1;
            if (f > smax)
                f = smax;
            s    = (hi > smax) ? smax : hi;
            r.first  = CW'(f);
            r.second = CW'(s);
            r.w      = t[15:0];
            return r;
        end
    endfunction

    function automatic logic [AW-1:0] tex_addr(input logic [LVL_W-1:0] lvl,
                                               input logic [AW-1:0] row,
                                               input logic [AW-1:0] col);
        return AW'(level_offset(lvl)) + (row << lvl) + col;
    endfunction

    function automatic logic [23:0] lerp_row(input logic [7:0] a, input logic [7:0] b,
                                             input logic [15:0] w);
        logic signed [25:0] p;
        begin
            p = $signed({1'b0, a, 16'd0}) +
                $signed({1'b0, b} - {1'b0, a}) * $signed({1'b0, w});
            return p[23:0];
        end
    endfunction

    function automatic logic [15:0] lerp_col(input logic [23:0] h0, input logic [23:0] h1,
                                             input logic [15:0] w);
        logic signed [41:0] r;
        begin
            r = $signed({2'b00, h0, 16'd0}) +
                $signed({1'b0, h1} - {1'b0, h0}) * $signed({1'b0, w}) + 42'sd8388608;
            return r[39:24];
        end
    endfunction

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [23:0] wdata;
    logic        we;

    state_t state_reg, state_next;
    logic [2:0] base_reg;
    logic [2:0] phase_reg, phase_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [9:0] acc_r_reg, acc_r_next, acc_g_reg, acc_g_next, acc_b_reg, acc_b_next;
    tap_t tx_reg, tx_next, ty_reg, ty_next;
    logic [23:0] t00_reg, t00_next, t10_reg, t10_next;
    logic [23:0] h0r_reg, h0r_next, h0g_reg, h0g_next, h0b_reg, h0b_next;
    logic [23:0] h1r_reg, h1r_next, h1g_reg, h1g_next, h1b_reg, h1b_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic [LVL_W-1:0] eff_level;
    logic [LVL_W-1:0] req_level;
    logic             in_fire;
    logic [CW-1:0]    dmax;
    logic [9:0]       sum_r, sum_g, sum_b;
    logic [CW-1:0]    sx, sy;

    assign eff_level = ({1'b0, base_reg} > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL)
                                                                : {1'b0, base_reg};
    assign req_level = (in_data.sample_level > eff_level) ? eff_level : in_data.sample_level;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign dmax      = CW'((32'd1 << (lvl_reg - LVL_W'(1))) - 32'd1);
    assign sum_r     = acc_r_reg + 10'(rdata_reg[23:16]);
    assign sum_g     = acc_g_reg + 10'(rdata_reg[15:8]);
    assign sum_b     = acc_b_reg + 10'(rdata_reg[7:0]);
    assign sx        = phase_reg[0] ? tx_reg.second : tx_reg.first;
    assign sy        = phase_reg[1] ? ty_reg.second : ty_reg.first;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        lvl_next       = lvl_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_r_next     = acc_r_reg;
        acc_g_next     = acc_g_reg;
        acc_b_next     = acc_b_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        t00_next       = t00_reg;
        t10_next       = t10_reg;
        h0r_next       = h0r_reg;
        h0g_next       = h0g_reg;
        h0b_next       = h0b_reg;
        h1r_next       = h1r_reg;
        h1g_next       = h1g_reg;
        h1b_next       = h1b_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        raddr          = '0;
        waddr          = '0;
        wdata          = '0;
        we             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.req_type)
                        REQ_WRITE:
                        begin
                            if ((32'(in_data.texel_index) >> (2 * eff_level)) == 32'd0)
                            begin
                                we    = 1'b1;
                                waddr = tex_addr(eff_level, '0, AW'(in_data.texel_index));
                                wdata = {in_data.red_in, in_data.green_in, in_data.blue_in};
                            end
                        end
                        REQ_BUILD:
                        begin
                            if (eff_level != '0)
                            begin
                                state_next = ST_BUILD;
                                lvl_next   = eff_level;
                                x_next     = '0;
                                y_next     = '0;
                                phase_next = '0;
                            end
                        end
                        REQ_SAMPLE:
                        begin
                            state_next = ST_SAMPLE;
                            phase_next = '0;
                            lvl_next   = req_level;
                            tx_next    = calc_tap({1'b0, in_data.coord_u[15:0]}, req_level);
                            ty_next    = calc_tap(17'd65536 - 17'(in_data.coord_v[15:0]),
                                                  req_level);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BUILD:
            begin
                raddr = tex_addr(lvl_reg, (AW'(y_reg) << 1) | AW'(phase_reg[1]),
                                 (AW'(x_reg) << 1) | AW'(phase_reg[0]));
                phase_next = phase_reg + 3'd1;
                if (phase_reg == 3'd1)
                begin
                    acc_r_next = 10'(rdata_reg[23:16]);
                    acc_g_next = 10'(rdata_reg[15:8]);
                    acc_b_next = 10'(rdata_reg[7:0]);
                end
                else if (phase_reg == 3'd2 || phase_reg == 3'd3)
                begin
                    acc_r_next = sum_r;
                    acc_g_next = sum_g;
                    acc_b_next = sum_b;
                end
                else if (phase_reg == 3'd4)
                begin
                    we         = 1'b1;
                    waddr      = tex_addr(lvl_reg - LVL_W'(1), AW'(y_reg), AW'(x_reg));
                    wdata      = {8'((sum_r + 10'd2) >> 2), 8'((sum_g + 10'd2) >> 2),
                                  8'((sum_b + 10'd2) >> 2)};
                    phase_next = '0;
                    if (x_reg != dmax)
                        x_next = x_reg + CW'(1);
                    else
                    begin
                        x_next = '0;
                        if (y_reg != dmax)
                            y_next = y_reg + CW'(1);
                        else
                        begin
                            y_next   = '0;
                            lvl_next = lvl_reg - LVL_W'(1);
                            if (lvl_reg == LVL_W'(1))
                                state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_SAMPLE:
            begin
                raddr      = tex_addr(lvl_reg, AW'(sy), AW'(sx));
                phase_next = phase_reg + 3'd1;
                if (phase_reg == 3'd1)
                    t00_next = rdata_reg;
                else if (phase_reg == 3'd2)
                begin
                    h0r_next = lerp_row(t00_reg[23:16], rdata_reg[23:16], tx_reg.w);
                    h0g_next = lerp_row(t00_reg[15:8], rdata_reg[15:8], tx_reg.w);
                    h0b_next = lerp_row(t00_reg[7:0], rdata_reg[7:0], tx_reg.w);
                end
                else if (phase_reg == 3'd3)
                    t10_next = rdata_reg;
                else if (phase_reg == 3'd4)
                begin
                    h1r_next   = lerp_row(t10_reg[23:16], rdata_reg[23:16], tx_reg.w);
                    h1g_next   = lerp_row(t10_reg[15:8], rdata_reg[15:8], tx_reg.w);
                    h1b_next   = lerp_row(t10_reg[7:0], rdata_reg[7:0], tx_reg.w);
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.red_out   = lerp_col(h0r_reg, h1r_reg, ty_reg.w);
                    out_data_next.green_out = lerp_col(h0g_reg, h1g_reg, ty_reg.w);
                    out_data_next.blue_out  = lerp_col(h0b_reg, h1b_reg, ty_reg.w);
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            phase_reg     <= '0;
            lvl_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            lvl_reg       <= lvl_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                base_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_r_reg    <= acc_r_next;
        acc_g_reg    <= acc_g_next;
        acc_b_reg    <= acc_b_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        t00_reg      <= t00_next;
        t10_reg      <= t10_next;
        h0r_reg      <= h0r_next;
        h0g_reg      <= h0g_next;
        h0b_reg      <= h0b_next;
        h1r_reg      <= h1r_next;
        h1g_reg      <= h1g_next;
        h1b_reg      <= h1b_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== sv/mbs_checker.sv =====
// ----------------------------------------------------------------------------
// Mipmap sampler port checker
// Concurrent checks on the ports of the mipmap sampler, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mipmap_build_and_bilinear_sampler_top_macros.svh"

module mbs_checker
    import mbs_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_item_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    `MBS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `MBS_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
    `MBS_ASSERT(a_out_range, clk, rst_n, out_valid |-> (out_data.red_out <= 16'(FULL_SCALE) && out_data.green_out <= 16'(FULL_SCALE) && out_data.blue_out <= 16'(FULL_SCALE)), "result above full scale")
    `MBS_ASSERT(a_no_spurious, clk, rst_n, in_valid && !in_stall && in_data.req_type != REQ_SAMPLE && !out_valid |=> !out_valid, "result without a sample transaction")

endmodule

bind mipmap_build_and_bilinear_sampler_top mbs_checker u_mbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// ===== test/mipmap_build_and_bilinear_sampler_top_tb.sv =====
// ----------------------------------------------------------------------------
// Mipmap sampler testbench
// Fills the base level at several base sizes, builds the mip chain and checks
// every bilinear sample transaction against a predictor of the texel store.
// ----------------------------------------------------------------------------
`default_nettype none

module mipmap_build_and_bilinear_sampler_top_tb;
    import mbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_WORDS = 21845;
    localparam int STALL_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_data;

    logic [23:0]  texel_mem [0:STORE_WORDS-1];
    int unsigned  level_sel;
    in_item_t     pending_items[$];
    out_item_t    expected_colors[$];
    int           errors;
    int           samples_checked;
    int           writes_sent;
    int           builds_sent;
    int           phases_run;
    int           idle_cycles;
    longint       cycle_count;

    mipmap_build_and_bilinear_sampler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned mip_base(input int unsigned n);
        return ((32'd1 << (2 * n)) - 1) / 3;
    endfunction

    function automatic void build_levels();
        int unsigned s;
        int unsigned src;
        int unsigned dst;
        int unsigned sum;
        logic [23:0] a;
        logic [23:0] b;
        logic [23:0] c;
        logic [23:0] d;
        logic [23:0] res;
        for (int n = level_sel; n > 0; n--)
        begin
            s = 1 << (n - 1);
            src = mip_base(n);
            dst = mip_base(n - 1);
            for (int y = 0; y < s; y++)
            begin
                for (int x = 0; x < s; x++)
                begin
                    a = texel_mem[src + 2 * y * 2 * s + 2 * x];
                    b = texel_mem[src + 2 * y * 2 * s + 2 * x + 1];
                    c = texel_mem[src + (2 * y + 1) * 2 * s + 2 * x];
                    d = texel_mem[src + (2 * y + 1) * 2 * s + 2 * x + 1];
                    for (int k = 0; k < 3; k++)
                    begin
                        sum = a[8*k +: 8] + b[8*k +: 8] + c[8*k +: 8] + d[8*k +: 8] + 2;
                        res[8*k +: 8] = 8'(sum >> 2);
                    end
                    texel_mem[dst + y * s + x] = res;
                end
            end
        end
    endfunction

    function automatic void tap_pair(input int unsigned c, input int unsigned lvl,
                                     output int unsigned first, output int unsigned second,
                                     output int unsigned w);
        longint unsigned t;
        int unsigned hi;
        int unsigned s;
        s = 1 << lvl;
        t = longint'(c) * s + 32768;
        hi = 32'(t >> 16);
        w = 32'(t & 64'hFFFF);
        first = (hi == 0) ? 0 : hi - 1;
        second = (hi > s - 1) ? s - 1 : hi;
        if (first > s - 1)
            first = s - 1;
    endfunction

    function automatic out_item_t bilinear_sample(input in_item_t it);
        int unsigned lvl;
        int unsigned s;
        int unsigned off;
        int unsigned x0;
        int unsigned x1;
        int unsigned y0;
        int unsigned y1;
        int unsigned wx;
        int unsigned wy;
        logic [23:0] t00;
        logic [23:0] t01;
        logic [23:0] t10;
        logic [23:0] t11;
        longint unsigned h0;
        longint unsigned h1;
        longint unsigned r;
        logic [15:0] chan [3];
        out_item_t o;
        lvl = (it.sample_level > level_sel) ? level_sel : it.sample_level;
        s = 1 << lvl;
        off = mip_base(lvl);
        tap_pair(it.coord_u[15:0], lvl, x0, x1, wx);
        tap_pair(65536 - it.coord_v[15:0], lvl, y0, y1, wy);
        t00 = texel_mem[off + y0 * s + x0];
        t01 = texel_mem[off + y0 * s + x1];
        t10 = texel_mem[off + y1 * s + x0];
        t11 = texel_mem[off + y1 * s + x1];
        for (int k = 0; k < 3; k++)
        begin
            h0 = longint'(t00[16-8*k +: 8]) * (65536 - wx) + longint'(t01[16-8*k +: 8]) * wx;
            h1 = longint'(t10[16-8*k +: 8]) * (65536 - wx) + longint'(t11[16-8*k +: 8]) * wx;
            r = h0 * (65536 - wy) + h1 * wy;
            chan[k] = 16'((r + (64'd1 << 23)) >> 24);
        end
        o.red_out = chan[0];
        o.green_out = chan[1];
        o.blue_out = chan[2];
        return o;
    endfunction

    function automatic void apply_transaction(input in_item_t it);
        case (req_t'(it.req_type))
            REQ_WRITE:
            begin
                if (it.texel_index < (1 << (2 * level_sel)))
                    texel_mem[mip_base(level_sel) + it.texel_index] =
                        {it.red_in, it.green_in, it.blue_in};
            end
            REQ_BUILD: build_levels();
            REQ_SAMPLE: expected_colors.push_back(bilinear_sample(it));
            default: ;
        endcase
    endfunction

    function automatic in_item_t random_item(input req_t kind);
        in_item_t it;
        it.req_type = kind;
        it.texel_index = 14'($urandom_range(0, 16383));
        it.red_in = 8'($urandom);
        it.green_in = 8'($urandom);
        it.blue_in = 8'($urandom);
        it.coord_u = $urandom;
        it.coord_v = $urandom;
        it.sample_level = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic void queue_write(input int unsigned idx, input logic [23:0] rgb);
        in_item_t it;
        it = random_item(REQ_WRITE);
        it.texel_index = 14'(idx);
        {it.red_in, it.green_in, it.blue_in} = rgb;
        pending_items.push_back(it);
        writes_sent++;
    endfunction

    function automatic void queue_sample(input logic [31:0] u, input logic [31:0] v,
                                         input logic [3:0] lvl);
        in_item_t it;
        it = random_item(REQ_SAMPLE);
        it.coord_u = u;
        it.coord_v = v;
        it.sample_level = lvl;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_fill_and_build(input int unsigned lvl, input bit extremes);
        for (int i = 0; i < (1 << (2 * lvl)); i++)
            queue_write(i, extremes ? ((i % 3 == 0) ? 24'hFFFFFF : (i % 3 == 1) ? 24'h000000
                                                   : 24'hFF00FF) : 24'($urandom));
        pending_items.push_back(random_item(REQ_BUILD));
        builds_sent++;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_base_level(input int unsigned lvl);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= 3'(lvl);
        do
            @(posedge clk);
        while (!cfg_ready);
        level_sel = lvl;
        cfg_valid <= 1'b0;
        phases_run++;
    endtask

    task automatic run_random_phase(input int unsigned lvl, input int count);
        int unsigned roll;
        in_item_t it;
        set_base_level(lvl);
        queue_fill_and_build(lvl, 1'b0);
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                pending_items.push_back(random_item(REQ_SAMPLE));
            else if (roll < 80)
                queue_write($urandom_range(0, (1 << (2 * lvl)) - 1), 24'($urandom));
            else if (roll < 87)
            begin
                it = random_item(REQ_WRITE);
                if (lvl < 7)
                    it.texel_index = 14'($urandom_range(1 << (2 * lvl), 16383));
                pending_items.push_back(it);
                writes_sent++;
            end
            else if (roll < 93)
            begin
                pending_items.push_back(random_item(REQ_BUILD));
                builds_sent++;
            end
            else
                pending_items.push_back(random_item(REQ_NONE));
        end
        pending_items.push_back(random_item(REQ_SAMPLE));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_transaction(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 &&
                    ((cycle_count % 8000) < 1500 || $urandom_range(0, 99) >= 34))
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    out_item_t exp_c;
                    exp_c = expected_colors.pop_front();
                    if (exp_c.red_out !== out_data.red_out)
                    begin
                        $display("%0t: red expected %0d actual %0d", $time, exp_c.red_out,
                                 out_data.red_out);
                        errors++;
                    end
                    if (exp_c.green_out !== out_data.green_out)
                    begin
                        $display("%0t: green expected %0d actual %0d", $time, exp_c.green_out,
                                 out_data.green_out);
                        errors++;
                    end
                    if (exp_c.blue_out !== out_data.blue_out)
                    begin
                        $display("%0t: blue expected %0d actual %0d", $time, exp_c.blue_out,
                                 out_data.blue_out);
                        errors++;
                    end
                    samples_checked++;
                end
            end
            out_stall <= ((cycle_count % 8000) >= 1500) && ($urandom_range(0, 99) < 34);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        samples_checked = 0;
        writes_sent = 0;
        builds_sent = 0;
        phases_run = 0;
        idle_cycles = 0;
        cycle_count = 0;
        level_sel = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks at a 4x4 base with black, white and magenta texels.
        set_base_level(2);
        queue_fill_and_build(2, 1'b1);
        queue_sample(32'h0000_0000, 32'h0000_0000, 4'd2);
        queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd2);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 4'd15);
        queue_sample(32'h0000_8000, 32'h0000_8000, 4'd1);
        queue_sample(32'h0000_2000, 32'hFFFF_E000, 4'd0);
        queue_sample(32'h7FFF_0001, 32'h8000_FFFE, 4'd2);
        queue_write(16383, 24'hFFFFFF);
        queue_write(16, 24'h123456);
        pending_items.push_back(random_item(REQ_NONE));
        queue_sample(32'h0001_C000, 32'h0000_4000, 4'd2);

        run_random_phase(0, 60);
        run_random_phase(1, 80);
        run_random_phase(3, 180);
        run_random_phase(4, 180);
        run_random_phase(2, 170);

        wait_idle();
        $display("Base levels 0 to 4 over %0d settings: %0d writes, %0d builds, %0d samples.",
                 phases_run, writes_sent, builds_sent, samples_checked);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
